### hdl/sm83_pkg.sv
package sm83_pkg;

  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,
    OP_ADC      = 5'd1,
    OP_SUB      = 5'd2,
    OP_SBC      = 5'd3,
    OP_AND      = 5'd4,
    OP_OR       = 5'd5,
    OP_XOR      = 5'd6,
    OP_CP       = 5'd7,
    OP_INC8     = 5'd8,
    OP_DEC8     = 5'd9,
    OP_RLC      = 5'd10,
    OP_RRC      = 5'd11,
    OP_RL       = 5'd12,
    OP_RR       = 5'd13,
    OP_SLA      = 5'd14,
    OP_SRA      = 5'd15,
    OP_SRL      = 5'd16,
    OP_SWAP     = 5'd17,
    OP_BIT      = 5'd18,
    OP_RES      = 5'd19,
    OP_SET      = 5'd20,
    OP_DAA      = 5'd21,
    OP_CPL      = 5'd22,
    OP_RLCA     = 5'd23,
    OP_RRCA     = 5'd24,
    OP_RLA      = 5'd25,
    OP_RRA      = 5'd26,
    OP_ADD16    = 5'd27,
    OP_ADD_SP_E = 5'd28,
    OP_INC16    = 5'd29,
    OP_DEC16    = 5'd30
  } alu_op_t;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [8:0] DAA_ADJ_LO = 9'h006;
  localparam logic [8:0] DAA_ADJ_HI = 9'h060;
  localparam logic [8:0] DAA_LIMIT  = 9'h09F;
  localparam logic [3:0] BCD_MAX    = 4'h9;

  typedef struct packed {
    alu_op_t     op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } item_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } res_t;

endpackage

### hdl/sm83_alu_with_flags.sv
// sm83 alu with flags
//
// item channel: item_valid / item_stall carry one operation per transaction
// (opcode, two 16-bit operands, bit index, incoming z/n/h/c flags).
// res channel: res_valid / res_stall carry the value and the new flags,
// exactly one result transaction per item transaction, in order.
//
// the item is taken into the input register, then the alu logic writes the
// result register. throughput: one item per cycle while res_stall is low;
// the alu is a single pass of adders and muxes between those two registers.
//
// when the receiver stalls, the result register holds its transaction and
// one more item is still taken into the input register; item_stall rises
// only when both registers are full and res_stall is high.
// reset (rst, synchronous) empties both registers; nothing is offered
// until a new item arrives.
module sm83_alu_with_flags (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  sm83_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_stall,
  output sm83_pkg::res_t  res
);

  logic            s1_valid;
  sm83_pkg::item_t s1_item;
  logic            res_open;
  logic            s1_load;
  sm83_pkg::res_t  res_next;

  assign res_open   = !res_valid || !res_stall;
  assign s1_load    = !s1_valid || res_open;
  assign item_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= item_valid;
      end
      if (res_open) begin
        res_valid <= s1_valid;
      end
    end
    if (item_valid && s1_load) begin
      s1_item <= item;
    end
    if (res_open && s1_valid) begin
      res <= res_next;
    end
  end

  always_comb begin
    logic [15:0] a16;
    logic [15:0] b16;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        cy;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [7:0]  r8;
    logic [7:0]  mask;
    logic [8:0]  daa9;
    logic        daa_c;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sext;
    logic [3:0]  fin;
    logic [3:0]  fl;
    logic [15:0] r16;

    a16   = s1_item.operand_a;
    b16   = s1_item.operand_b;
    a     = a16[7:0];
    b     = b16[7:0];
    fin   = s1_item.flags_in;
    cin   = fin[sm83_pkg::FLAG_C];
    cy    = cin && (s1_item.op == sm83_pkg::OP_ADC || s1_item.op == sm83_pkg::OP_SBC);
    sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cy};
    sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
    dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cy};
    dif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
    mask  = 8'd1 << s1_item.bit_index;
    sum17 = {1'b0, a16} + {1'b0, b16};
    sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    sext  = {{8{b[7]}}, b};

    daa9  = {1'b0, a};
    daa_c = cin;
    if (!fin[sm83_pkg::FLAG_N]) begin
      if (fin[sm83_pkg::FLAG_H] || (a[3:0] > sm83_pkg::BCD_MAX)) begin
        daa9 = daa9 + sm83_pkg::DAA_ADJ_LO;
      end
      if (cin || (daa9 > sm83_pkg::DAA_LIMIT)) begin
        daa9  = daa9 + sm83_pkg::DAA_ADJ_HI;
        daa_c = 1'b1;
      end
    end else begin
      if (fin[sm83_pkg::FLAG_H]) begin
        daa9 = daa9 - sm83_pkg::DAA_ADJ_LO;
      end
      if (cin) begin
        daa9 = daa9 - sm83_pkg::DAA_ADJ_HI;
      end
    end

    r8  = 8'd0;
    r16 = a16;
    fl  = fin;
    unique case (s1_item.op)
      sm83_pkg::OP_ADD, sm83_pkg::OP_ADC: begin
        r8  = sum9[7:0];
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 1'b0, sum5[4], sum9[8]};
      end
      sm83_pkg::OP_SUB, sm83_pkg::OP_SBC: begin
        r8  = dif9[7:0];
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 1'b1, dif5[4], dif9[8]};
      end
      sm83_pkg::OP_CP: begin
        fl = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
      end
      sm83_pkg::OP_AND: begin
        r8  = a & b;
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      sm83_pkg::OP_OR: begin
        r8  = a | b;
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 3'b000};
      end
      sm83_pkg::OP_XOR: begin
        r8  = a ^ b;
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 3'b000};
      end
      sm83_pkg::OP_INC8: begin
        r8  = a + 8'd1;
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
      end
      sm83_pkg::OP_DEC8: begin
        r8  = a - 8'd1;
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
      end
      sm83_pkg::OP_RLC, sm83_pkg::OP_RLCA: begin
        r8  = {a[6:0], a[7]};
        r16 = {8'd0, r8};
        fl  = {(s1_item.op == sm83_pkg::OP_RLC) && (r8 == 8'd0), 2'b00, a[7]};
      end
      sm83_pkg::OP_RRC, sm83_pkg::OP_RRCA: begin
        r8  = {a[0], a[7:1]};
        r16 = {8'd0, r8};
        fl  = {(s1_item.op == sm83_pkg::OP_RRC) && (r8 == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_RL, sm83_pkg::OP_RLA: begin
        r8  = {a[6:0], cin};
        r16 = {8'd0, r8};
        fl  = {(s1_item.op == sm83_pkg::OP_RL) && (r8 == 8'd0), 2'b00, a[7]};
      end
      sm83_pkg::OP_RR, sm83_pkg::OP_RRA: begin
        r8  = {cin, a[7:1]};
        r16 = {8'd0, r8};
        fl  = {(s1_item.op == sm83_pkg::OP_RR) && (r8 == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_SLA: begin
        r8  = {a[6:0], 1'b0};
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 2'b00, a[7]};
      end
      sm83_pkg::OP_SRA: begin
        r8  = {a[7], a[7:1]};
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 2'b00, a[0]};
      end
      sm83_pkg::OP_SRL: begin
        r8  = {1'b0, a[7:1]};
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 2'b00, a[0]};
      end
      sm83_pkg::OP_SWAP: begin
        r8  = {a[3:0], a[7:4]};
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, 3'b000};
      end
      sm83_pkg::OP_BIT: begin
        fl = {(a & mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      sm83_pkg::OP_RES: begin
        r8  = a & ~mask;
        r16 = {8'd0, r8};
      end
      sm83_pkg::OP_SET: begin
        r8  = a | mask;
        r16 = {8'd0, r8};
      end
      sm83_pkg::OP_DAA: begin
        r8  = daa9[7:0];
        r16 = {8'd0, r8};
        fl  = {r8 == 8'd0, fin[sm83_pkg::FLAG_N], 1'b0, daa_c};
      end
      sm83_pkg::OP_CPL: begin
        r8  = ~a;
        r16 = {8'd0, r8};
        fl  = {fin[sm83_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      sm83_pkg::OP_ADD16: begin
        r16 = sum17[15:0];
        fl  = {fin[sm83_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      sm83_pkg::OP_ADD_SP_E: begin
        r16 = a16 + sext;
        fl  = {2'b00, sum5[4], sum9[8]};
      end
      sm83_pkg::OP_INC16: begin
        r16 = a16 + 16'd1;
      end
      sm83_pkg::OP_DEC16: begin
        r16 = a16 - 16'd1;
      end
      default: begin
        r16 = a16;
        fl  = fin;
      end
    endcase

    res_next.result    = r16;
    res_next.flags_out = fl;
  end

  // pipeline bookkeeping checks
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !res_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && res_valid && res_stall)
    else $error("item stalled while pipeline has room");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> s1_valid)
    else $error("accepted transaction lost from input register");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_open |=> res_valid)
    else $error("input register advanced without a result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_open |=> s1_valid && $stable(s1_item))
    else $error("held transaction changed while result stalled");

endmodule

### tb/sv/sm83_alu_checker.sv
module sm83_alu_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_stall,
  input  sm83_pkg::item_t item,
  input  logic            res_valid,
  input  logic            res_stall,
  input  sm83_pkg::res_t  res,
  output int unsigned     err_count,
  output int unsigned     pending
);

  typedef struct packed {
    sm83_pkg::item_t cmd;
    sm83_pkg::res_t  want;
  } alu_expect_t;

  alu_expect_t in_flight[$];
  int unsigned errors = 0;
  int unsigned open_count = 0;

  assign err_count = errors;
  assign pending = open_count;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic sm83_pkg::res_t alu_outcome(input sm83_pkg::item_t cmd);
    logic [15:0] a16, b16, val;
    logic [7:0] a, b, r8;
    logic z, n, h, c, cy, wide;
    logic [4:0] nib;
    logic [8:0] sum9;
    logic [12:0] sum13;
    logic [16:0] sum17;
    sm83_pkg::res_t out;
    a16 = cmd.operand_a;
    b16 = cmd.operand_b;
    a = a16[7:0];
    b = b16[7:0];
    z = cmd.flags_in[sm83_pkg::FLAG_Z];
    n = cmd.flags_in[sm83_pkg::FLAG_N];
    h = cmd.flags_in[sm83_pkg::FLAG_H];
    c = cmd.flags_in[sm83_pkg::FLAG_C];
    cy = 1'b0;
    r8 = a;
    val = a16;
    wide = 1'b0;
    case (cmd.op)
      sm83_pkg::OP_ADD, sm83_pkg::OP_ADC: begin
        cy = (cmd.op == sm83_pkg::OP_ADC) ? c : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cy};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
        r8 = sum9[7:0];
        z = (r8 == 8'h00);
        n = 1'b0;
        h = nib[4];
        c = sum9[8];
      end
      sm83_pkg::OP_SUB, sm83_pkg::OP_SBC, sm83_pkg::OP_CP: begin
        cy = (cmd.op == sm83_pkg::OP_SBC) ? c : 1'b0;
        r8 = a - b - {7'd0, cy};
        nib = {1'b0, b[3:0]} + {4'd0, cy};
        sum9 = {1'b0, b} + {8'd0, cy};
        z = (r8 == 8'h00);
        n = 1'b1;
        h = {1'b0, a[3:0]} < nib;
        c = {1'b0, a} < sum9;
        wide = (cmd.op == sm83_pkg::OP_CP);
      end
      sm83_pkg::OP_AND, sm83_pkg::OP_OR, sm83_pkg::OP_XOR: begin
        if (cmd.op == sm83_pkg::OP_AND) r8 = a & b;
        else if (cmd.op == sm83_pkg::OP_OR) r8 = a | b;
        else r8 = a ^ b;
        z = (r8 == 8'h00);
        n = 1'b0;
        h = (cmd.op == sm83_pkg::OP_AND);
        c = 1'b0;
      end
      sm83_pkg::OP_INC8: begin
        r8 = a + 8'h01;
        z = (r8 == 8'h00);
        n = 1'b0;
        h = (a[3:0] == 4'hF);
      end
      sm83_pkg::OP_DEC8: begin
        r8 = a - 8'h01;
        z = (r8 == 8'h00);
        n = 1'b1;
        h = (a[3:0] == 4'h0);
      end
      sm83_pkg::OP_RLC, sm83_pkg::OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        z = (cmd.op == sm83_pkg::OP_RLC) && (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = a[7];
      end
      sm83_pkg::OP_RRC, sm83_pkg::OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        z = (cmd.op == sm83_pkg::OP_RRC) && (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = a[0];
      end
      sm83_pkg::OP_RL, sm83_pkg::OP_RLA: begin
        r8 = {a[6:0], c};
        z = (cmd.op == sm83_pkg::OP_RL) && (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = a[7];
      end
      sm83_pkg::OP_RR, sm83_pkg::OP_RRA: begin
        r8 = {c, a[7:1]};
        z = (cmd.op == sm83_pkg::OP_RR) && (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = a[0];
      end
      sm83_pkg::OP_SLA, sm83_pkg::OP_SRA, sm83_pkg::OP_SRL: begin
        if (cmd.op == sm83_pkg::OP_SLA) r8 = {a[6:0], 1'b0};
        else if (cmd.op == sm83_pkg::OP_SRA) r8 = {a[7], a[7:1]};
        else r8 = {1'b0, a[7:1]};
        z = (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = (cmd.op == sm83_pkg::OP_SLA) ? a[7] : a[0];
      end
      sm83_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        z = (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      sm83_pkg::OP_BIT: begin
        wide = 1'b1;
        z = !a[cmd.bit_index];
        n = 1'b0;
        h = 1'b1;
      end
      sm83_pkg::OP_RES: r8 = a & ~(8'h01 << cmd.bit_index);
      sm83_pkg::OP_SET: r8 = a | (8'h01 << cmd.bit_index);
      sm83_pkg::OP_DAA: begin
        sum9 = {1'b0, a};
        if (!n) begin
          if (h || a[3:0] > 4'h9) sum9 = sum9 + 9'h006;
          if (c || sum9 > 9'h09F) begin
            sum9 = sum9 + 9'h060;
            c = 1'b1;
          end
        end else begin
          if (h) sum9 = sum9 - 9'h006;
          if (c) sum9 = sum9 - 9'h060;
        end
        r8 = sum9[7:0];
        z = (r8 == 8'h00);
        h = 1'b0;
      end
      sm83_pkg::OP_CPL: begin
        r8 = ~a;
        n = 1'b1;
        h = 1'b1;
      end
      sm83_pkg::OP_ADD16: begin
        wide = 1'b1;
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        val = sum17[15:0];
        n = 1'b0;
        h = sum13[12];
        c = sum17[16];
      end
      sm83_pkg::OP_ADD_SP_E: begin
        wide = 1'b1;
        val = a16 + {{8{b[7]}}, b};
        nib = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, a16[7:0]} + {1'b0, b};
        z = 1'b0;
        n = 1'b0;
        h = nib[4];
        c = sum9[8];
      end
      sm83_pkg::OP_INC16: begin
        wide = 1'b1;
        val = a16 + 16'h0001;
      end
      sm83_pkg::OP_DEC16: begin
        wide = 1'b1;
        val = a16 - 16'h0001;
      end
      default: wide = 1'b1;
    endcase
    out.result = wide ? val : {8'h00, r8};
    out.flags_out[sm83_pkg::FLAG_Z] = z;
    out.flags_out[sm83_pkg::FLAG_N] = n;
    out.flags_out[sm83_pkg::FLAG_H] = h;
    out.flags_out[sm83_pkg::FLAG_C] = c;
    return out;
  endfunction

  always @(posedge clk) begin
    alu_expect_t head;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (in_flight.size() == 0) begin
          report_mismatch($sformatf("result %h flags %h with no transaction outstanding",
                                    res.result, res.flags_out));
        end else begin
          head = in_flight.pop_front();
          if (res.result !== head.want.result)
            report_mismatch($sformatf("%s a %h b %h bit %0d flags %h: result %h, want %h",
                                      head.cmd.op.name(), head.cmd.operand_a,
                                      head.cmd.operand_b, head.cmd.bit_index,
                                      head.cmd.flags_in, res.result, head.want.result));
          if (res.flags_out !== head.want.flags_out)
            report_mismatch($sformatf("%s a %h b %h bit %0d flags %h: flags %b, want %b",
                                      head.cmd.op.name(), head.cmd.operand_a,
                                      head.cmd.operand_b, head.cmd.bit_index,
                                      head.cmd.flags_in, res.flags_out,
                                      head.want.flags_out));
        end
      end
      if (item_valid && !item_stall)
        in_flight.push_back(alu_expect_t'{item, alu_outcome(item)});
      open_count = in_flight.size();
    end
  end

endmodule

### tb/sv/sm83_alu_with_flags_test.sv
module sm83_alu_with_flags_test;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  sm83_pkg::item_t item = '0;
  logic            res_valid;
  logic            res_stall = 1'b0;
  sm83_pkg::res_t  res;

  int unsigned err_count;
  int unsigned pending;
  int unsigned burst_left = 0;

  always #5 clk = ~clk;

  sm83_alu_with_flags i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  sm83_alu_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // one transaction, then maybe a gap between bursts
  task automatic send_item(input sm83_pkg::item_t x);
    int unsigned gap;
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      3: return 16'h0F00 | 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver stall pattern with one long hold-off
  initial begin
    int unsigned cycles;
    int unsigned mode;
    bit held;
    cycles = 0;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && cycles >= 300) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 40)) begin
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= ~res_stall;
        endcase
        @(posedge clk);
        cycles++;
      end
    end
  end

  initial begin
    int k;
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k <= int'(sm83_pkg::OP_DEC16); k++)
      send_item(sm83_pkg::item_t'{sm83_pkg::alu_op_t'(k), 16'hFFFF, 16'hFFFF, 3'd7, 4'hF});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_DAA, 16'h0045, 16'h0000, 3'd0, 4'h6});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_CP, 16'h1242, 16'h0042, 3'd0, 4'h0});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_BIT, 16'h00FE, 16'h0000, 3'd0, 4'h0});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_ADD_SP_E, 16'h00FF, 16'h0001, 3'd0, 4'hF});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h0});
    send_item(sm83_pkg::item_t'{sm83_pkg::OP_SUB, 16'h0000, 16'h0001, 3'd0, 4'h0});

    repeat (1700)
      send_item(sm83_pkg::item_t'{
                  sm83_pkg::alu_op_t'($urandom_range(0, int'(sm83_pkg::OP_DEC16))),
                  rand_word(), rand_word(), 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15))});

    item_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending == 0) repeat (8) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
